[sv/tile_map_pixel_fetcher_top_assert.svh]
// Assertion macros for the tile map pixel fetcher.
`ifndef TILE_MAP_PIXEL_FETCHER_TOP_ASSERT_SVH
`define TILE_MAP_PIXEL_FETCHER_TOP_ASSERT_SVH
`ifndef SYNTH
`define TMPF_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tmpf assertion failed");
`define TMPF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tmpf assertion failed");
`else
`define TMPF_ASSERT_SAME(lbl, ante, cons)
`define TMPF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[sv/tmpf_pkg.sv]
// Types and constants shared by the tile map pixel fetcher modules.
package tmpf_pkg;

   localparam int VRAM_AW = 14;
   localparam int BANK_AW = 13;
   localparam int DIV_W   = 3;
   localparam int COL_W   = 5;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_LINE  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      PH_MAP  = 3'd0,
      PH_ATTR = 3'd1,
      PH_LOW  = 3'd2,
      PH_HIGH = 3'd3,
      PH_PUSH = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      LD_INDEX = 2'd0,
      LD_ATTR  = 2'd1,
      LD_LOW   = 2'd2,
      LD_HIGH  = 2'd3
   } load_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic [VRAM_AW-1:0] vram_addr;
      logic [7:0]         vram_data;
      logic               fifo_ready;
      logic [7:0]         screen_x;
      logic [7:0]         line;
      logic [7:0]         scroll_x;
      logic [7:0]         scroll_y;
      logic [7:0]         window_x;
      logic [7:0]         window_y;
      logic [7:0]         lcd_control;
      logic [7:0]         window_line;
   } req_type;

   typedef struct packed {
      logic       push_valid;
      logic [7:0] row_low;
      logic [7:0] row_high;
      logic [7:0] tile_attr;
      logic       flush_fifos;
   } rsp_type;

   typedef struct packed {
      logic               en;
      logic               we;
      logic [VRAM_AW-1:0] addr;
      logic [7:0]         wdata;
   } mem_req_type;

endpackage

[sv/tmpf_vram.sv]
// Two-bank video memory, one port, registered read data.
module tmpf_vram
   import tmpf_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output logic [7:0]  rdata
);

   logic [7:0] vram_mem [2**VRAM_AW];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.en && mem_req.we) begin
         vram_mem[mem_req.addr] <= mem_req.wdata;
      end
      if (mem_req.en && !mem_req.we) begin
         rdata_ff <= vram_mem[mem_req.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[sv/tmpf_fetch.sv]
// Fetch sequencer: dot divider, phases, window start, address generation and load capture.
`include "tile_map_pixel_fetcher_top_assert.svh"
module tmpf_fetch
   import tmpf_pkg::*;
#(
   parameter int STEP_DOTS = 2
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  req_type     req,
   input  logic        cgb_mode,
   input  logic [7:0]  rdata,
   output mem_req_type mem_req,
   output rsp_type     rsp
);

   phase_type        phase_ff, phase_in;
   logic [DIV_W-1:0] div_ff, div_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             win_ff, win_in;
   logic [7:0]       index_ff, index_in;
   logic [7:0]       attr_ff, attr_in;
   logic [7:0]       low_ff, low_in;
   logic [7:0]       high_ff, high_in;
   logic             pend_ff, pend_in;
   load_type         pend_sel_ff, pend_sel_in;

   op_type           op;
   logic             is_tick, step, start, push, win_now;
   logic [DIV_W:0]   div_next;
   phase_type        phase_now;
   logic [COL_W-1:0] col_now;
   logic [7:0]       index_cur, attr_cur, low_cur, high_cur;
   logic [7:0]       bg_y;
   logic [4:0]       map_ty, map_tx;
   logic             map_sel;
   logic [BANK_AW-1:0] map_off, data_off;
   logic [2:0]       row;

   always_comb begin
      op       = op_type'(req.operation);
      is_tick  = accept && (op == OP_TICK);
      div_next = {1'b0, div_ff} + 1'b1;
      step     = is_tick && !(div_next < (DIV_W+1)'(STEP_DOTS));
      start    = step && req.lcd_control[5] && (req.line >= req.window_y)
                 && (({1'b0, req.screen_x} + 9'd7) >= {1'b0, req.window_x}) && !win_ff;
      win_now   = win_ff || start;
      phase_now = start ? PH_MAP : phase_ff;
      col_now   = start ? '0 : col_ff;

      index_cur = (pend_ff && pend_sel_ff == LD_INDEX) ? rdata : index_ff;
      attr_cur  = (pend_ff && pend_sel_ff == LD_ATTR)  ? rdata : attr_ff;
      low_cur   = (pend_ff && pend_sel_ff == LD_LOW)   ? rdata : low_ff;
      high_cur  = (pend_ff && pend_sel_ff == LD_HIGH)  ? rdata : high_ff;

      bg_y = req.line + req.scroll_y;
      if (win_now) begin
         map_sel = req.lcd_control[6];
         map_ty  = req.window_line[7:3];
         map_tx  = col_now;
         row     = req.window_line[2:0];
      end else begin
         map_sel = req.lcd_control[3];
         map_ty  = bg_y[7:3];
         map_tx  = req.scroll_x[7:3] + col_now;
         row     = bg_y[2:0];
      end
      if (attr_cur[6]) begin
         row = ~row;
      end
      map_off  = {2'b11, map_sel, map_ty, map_tx};
      data_off = {~req.lcd_control[4] & ~index_cur[7], index_cur, row, 1'b0};
   end

   always_comb begin
      mem_req     = '0;
      pend_in     = 1'b0;
      pend_sel_in = LD_INDEX;
      push        = 1'b0;
      if (accept && op == OP_WRITE) begin
         mem_req.en    = 1'b1;
         mem_req.we    = 1'b1;
         mem_req.addr  = req.vram_addr;
         mem_req.wdata = req.vram_data;
      end else if (step) begin
         case (phase_now)
            PH_MAP: begin
               mem_req.en  = 1'b1;
               mem_req.addr = {1'b0, map_off};
               pend_in     = 1'b1;
               pend_sel_in = LD_INDEX;
            end
            PH_ATTR: begin
               mem_req.en  = cgb_mode;
               mem_req.addr = {1'b1, map_off};
               pend_in     = cgb_mode;
               pend_sel_in = LD_ATTR;
            end
            PH_LOW: begin
               mem_req.en  = 1'b1;
               mem_req.addr = {attr_cur[3], data_off};
               pend_in     = 1'b1;
               pend_sel_in = LD_LOW;
            end
            PH_HIGH: begin
               mem_req.en  = 1'b1;
               mem_req.addr = {attr_cur[3], data_off[BANK_AW-1:1], 1'b1};
               pend_in     = 1'b1;
               pend_sel_in = LD_HIGH;
            end
            default: begin
               push = req.fifo_ready;
            end
         endcase
      end
   end

   always_comb begin
      phase_in = phase_ff;
      div_in   = div_ff;
      col_in   = col_ff;
      win_in   = win_ff;
      index_in = index_cur;
      attr_in  = attr_cur;
      low_in   = low_cur;
      high_in  = high_cur;
      if (accept && op == OP_LINE) begin
         phase_in = PH_MAP;
         div_in   = '0;
         col_in   = '0;
         win_in   = 1'b0;
         index_in = '0;
         attr_in  = '0;
         low_in   = '0;
         high_in  = '0;
      end else if (is_tick && !step) begin
         div_in = div_next[DIV_W-1:0];
      end else if (step) begin
         div_in = '0;
         win_in = win_now;
         col_in = col_now;
         case (phase_now)
            PH_MAP:  phase_in = PH_ATTR;
            PH_ATTR: begin
               phase_in = PH_LOW;
               if (!cgb_mode) begin
                  attr_in = '0;
               end
            end
            PH_LOW:  phase_in = PH_HIGH;
            PH_HIGH: phase_in = PH_PUSH;
            default: begin
               if (push) begin
                  col_in   = col_now + 1'b1;
                  phase_in = PH_MAP;
               end else begin
                  phase_in = PH_PUSH;
               end
            end
         endcase
      end
   end

   always_comb begin
      rsp             = '0;
      rsp.flush_fifos = start;
      if (push) begin
         rsp.push_valid = 1'b1;
         rsp.row_low    = low_cur;
         rsp.row_high   = high_cur;
         rsp.tile_attr  = attr_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_MAP;
         div_ff      <= '0;
         col_ff      <= '0;
         win_ff      <= 1'b0;
         index_ff    <= '0;
         attr_ff     <= '0;
         low_ff      <= '0;
         high_ff     <= '0;
         pend_ff     <= 1'b0;
         pend_sel_ff <= LD_INDEX;
      end else begin
         phase_ff    <= phase_in;
         div_ff      <= div_in;
         col_ff      <= col_in;
         win_ff      <= win_in;
         index_ff    <= index_in;
         attr_ff     <= attr_in;
         low_ff      <= low_in;
         high_ff     <= high_in;
         pend_ff     <= pend_in;
         pend_sel_ff <= pend_sel_in;
      end
   end

   `TMPF_ASSERT_NEXT(a_read_sets_pend, mem_req.en && !mem_req.we, pend_ff)
   `TMPF_ASSERT_NEXT(a_start_sets_win, start, win_ff && phase_ff == PH_ATTR)
   `TMPF_ASSERT_NEXT(a_push_to_map, push, phase_ff == PH_MAP)
   `TMPF_ASSERT_SAME(a_flush_on_step, rsp.flush_fifos, step && !win_ff)

endmodule

[sv/tile_map_pixel_fetcher_top.sv]
// Top level of the tile map pixel fetcher: stream ports, register port, output register.
//  channel | direction | handshake
//  req     | in        | req_tvalid / req_tready, tuser = operation
//  rsp     | out       | rsp_tvalid / rsp_tready, one item per req item
//  csr     | in/out    | APB-style, pready always high
// One item per cycle while req_tready is high; each req item yields one rsp item,
// registered, in the cycle after it is accepted. The single VRAM port serves at
// most one read or one write per item; read data from the previous item is
// forwarded into this item's address and result. rsp holds in a one-deep output
// register; req_tready drops only while that register is full and rsp_tready is low.
module tile_map_pixel_fetcher_top
   import tmpf_pkg::*;
#(
   parameter int STEP_DOTS = 2
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // operation[1:0]
   input  logic [1:0]  req_tuser,
   // vram_addr[13:0], vram_data[21:14], fifo_ready[22], screen_x[30:23],
   // line[38:31], scroll_x[46:39], scroll_y[54:47], window_x[62:55],
   // window_y[70:63], lcd_control[78:71], window_line[86:79], zero[87]
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // push_valid[0], row_low[8:1], row_high[16:9], tile_attr[24:17],
   // flush_fifos[25], zero[31:26]
   output logic [31:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   req_type     req;
   rsp_type     rsp;
   mem_req_type mem_req;
   logic [7:0]  rdata;
   logic        accept;
   logic        cgb_ff, cgb_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   assign req = '{
      operation:   req_tuser,
      vram_addr:   req_tdata[13:0],
      vram_data:   req_tdata[21:14],
      fifo_ready:  req_tdata[22],
      screen_x:    req_tdata[30:23],
      line:        req_tdata[38:31],
      scroll_x:    req_tdata[46:39],
      scroll_y:    req_tdata[54:47],
      window_x:    req_tdata[62:55],
      window_y:    req_tdata[70:63],
      lcd_control: req_tdata[78:71],
      window_line: req_tdata[86:79]
   };

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   tmpf_fetch #(.STEP_DOTS(STEP_DOTS)) u_fetch (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req),
      .cgb_mode (cgb_ff),
      .rdata    (rdata),
      .mem_req  (mem_req),
      .rsp      (rsp)
   );

   tmpf_vram u_vram (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_in       = rsp;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      cgb_in = cgb_ff;
      if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         cgb_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cgb_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cgb_ff       <= cgb_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.flush_fifos, rsp_ff.tile_attr, rsp_ff.row_high,
                        rsp_ff.row_low, rsp_ff.push_valid};
   assign csr_prdata = {31'd0, cgb_ff & ~csr_paddr[2]};
   assign csr_pready = 1'b1;

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the tile map pixel fetcher: stream stimulus, item-level predictor.
module tb_top;
   import tmpf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STEP_DOTS    = 2;
   localparam int BANK_BYTES   = 8192;
   localparam int VRAM_BYTES   = 2 * BANK_BYTES;
   localparam int MAP_LO       = 'h1800;
   localparam int MAP_HI       = 'h1C00;
   localparam int SIGNED_BASE  = 'h1000;
   localparam int WIN_X_OFFSET = 7;
   localparam int LCDC_BG_MAP    = 3;
   localparam int LCDC_DATA_MODE = 4;
   localparam int LCDC_WIN_EN    = 5;
   localparam int LCDC_WIN_MAP   = 6;
   localparam int ATTR_BANK  = 3;
   localparam int ATTR_YFLIP = 6;
   localparam logic [1:0] OP_UNKNOWN   = 2'd3;
   localparam logic [2:0] CSR_CGB_MODE = 3'd0;
   localparam logic [2:0] CSR_UNMAPPED = 3'd4;
   localparam int QUIET_LIMIT  = 2000;
   localparam int SETTLE       = 4;
   localparam int HOLD_CYCLES  = 200;
   localparam int MAP_ROWS     = 2;
   localparam int TILE_PICKS   = 4;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;
   logic [87:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor state
   logic       cgb_on;
   phase_type  fetch_ph;
   logic [2:0] div_count;
   logic [4:0] tile_col;
   logic       win_on;
   logic [7:0] tile_idx;
   logic [7:0] tile_attr_q;
   logic [7:0] plane_lo;
   logic [7:0] plane_hi;
   logic [7:0] vram_img [0:VRAM_BYTES-1];

   rsp_type     fetch_results_due[$];
   dir_row_type stim_table[$];
   int          load_addrs[$];
   req_type     scan_ctx;
   int mismatches    = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left     = 0;
   int quiet         = 0;

   tile_map_pixel_fetcher_top #(.STEP_DOTS(STEP_DOTS)) dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_psel && csr_penable))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
         $display("** tile_map_pixel_fetcher_top: FAILED **");
         $finish;
      end
   end

   task automatic flag_mismatch(input string what, input int want, input int got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s: expected %0h, got %0h", what, want, got);
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.push_valid  = rsp_tdata[0];
         got.row_low     = rsp_tdata[8:1];
         got.row_high    = rsp_tdata[16:9];
         got.tile_attr   = rsp_tdata[24:17];
         got.flush_fifos = rsp_tdata[25];
         if (fetch_results_due.size() == 0) begin
            flag_mismatch("item with nothing expected", 0, rsp_tdata);
         end else begin
            want = fetch_results_due.pop_front();
            if (got.push_valid != want.push_valid)
               flag_mismatch("push_valid", want.push_valid, got.push_valid);
            if (got.row_low != want.row_low)
               flag_mismatch("row_low", want.row_low, got.row_low);
            if (got.row_high != want.row_high)
               flag_mismatch("row_high", want.row_high, got.row_high);
            if (got.tile_attr != want.tile_attr)
               flag_mismatch("tile_attr", want.tile_attr, got.tile_attr);
            if (got.flush_fifos != want.flush_fifos)
               flag_mismatch("flush_fifos", want.flush_fifos, got.flush_fifos);
         end
      end
   end

   function automatic logic [12:0] map_entry(req_type r);
      logic [7:0] ysum;
      int base, ty, tx;
      ysum = r.line + r.scroll_y;
      if (!win_on) begin
         base = r.lcd_control[LCDC_BG_MAP] ? MAP_HI : MAP_LO;
         ty = ysum >> 3;
         tx = (int'(r.scroll_x >> 3) + int'(tile_col)) & 31;
      end else begin
         base = r.lcd_control[LCDC_WIN_MAP] ? MAP_HI : MAP_LO;
         ty = r.window_line >> 3;
         tx = tile_col;
      end
      return 13'(base + ty * 32 + tx);
   endfunction

   function automatic logic [12:0] tile_data_addr(req_type r, int plane);
      logic [7:0] ysum;
      int row, base;
      ysum = r.line + r.scroll_y;
      row = win_on ? int'(r.window_line[2:0]) : int'(ysum[2:0]);
      if (tile_attr_q[ATTR_YFLIP])
         row = 7 - row;
      if (r.lcd_control[LCDC_DATA_MODE])
         base = int'(tile_idx) * 16;
      else
         base = SIGNED_BASE + int'($signed(tile_idx)) * 16;
      return 13'(base + row * 2 + plane);
   endfunction

   task automatic predict_fetch(input req_type r, output rsp_type res);
      int wx_edge;
      res = '0;
      case (r.operation)
         OP_WRITE: vram_img[r.vram_addr] = r.vram_data;
         OP_LINE: begin
            fetch_ph = PH_MAP;
            div_count = '0;
            tile_col = '0;
            win_on = 1'b0;
            tile_idx = '0;
            tile_attr_q = '0;
            plane_lo = '0;
            plane_hi = '0;
         end
         OP_TICK: begin
            if (div_count + 1 < STEP_DOTS) begin
               div_count++;
            end else begin
               div_count = '0;
               wx_edge = int'(r.window_x) - WIN_X_OFFSET;
               if (r.lcd_control[LCDC_WIN_EN] && r.line >= r.window_y &&
                   int'(r.screen_x) >= wx_edge && !win_on) begin
                  win_on = 1'b1;
                  fetch_ph = PH_MAP;
                  tile_col = '0;
                  res.flush_fifos = 1'b1;
               end
               case (fetch_ph)
                  PH_MAP: begin
                     tile_idx = vram_img[{1'b0, map_entry(r)}];
                     fetch_ph = PH_ATTR;
                  end
                  PH_ATTR: begin
                     tile_attr_q = cgb_on ? vram_img[{1'b1, map_entry(r)}] : 8'h00;
                     fetch_ph = PH_LOW;
                  end
                  PH_LOW: begin
                     plane_lo = vram_img[{tile_attr_q[ATTR_BANK], tile_data_addr(r, 0)}];
                     fetch_ph = PH_HIGH;
                  end
                  PH_HIGH: begin
                     plane_hi = vram_img[{tile_attr_q[ATTR_BANK], tile_data_addr(r, 1)}];
                     fetch_ph = PH_PUSH;
                  end
                  default: begin
                     if (r.fifo_ready) begin
                        res.push_valid = 1'b1;
                        res.row_low = plane_lo;
                        res.row_high = plane_hi;
                        res.tile_attr = tile_attr_q;
                        tile_col++;
                        fetch_ph = PH_MAP;
                     end
                  end
               endcase
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_item(input req_type r, input bit typed, input rsp_type want);
      rsp_type res;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= r.operation;
      req_tdata <= {1'b0, r.window_line, r.lcd_control, r.window_y, r.window_x, r.scroll_y,
                    r.scroll_x, r.line, r.screen_x, r.fifo_ready, r.vram_data, r.vram_addr};
      do
         @(posedge clock);
      while (!req_tready);
      predict_fetch(r, res);
      fetch_results_due.push_back(typed ? want : res);
   endtask

   task automatic csr_cycle(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (wr && addr == CSR_CGB_MODE)
         cgb_on = wdata[0];
   endtask

   task automatic set_cgb_mode(input logic mode);
      logic [31:0] rd;
      csr_cycle(1'b1, CSR_CGB_MODE, {31'b0, mode}, rd);
      csr_cycle(1'b1, CSR_UNMAPPED, '1, rd);
      csr_cycle(1'b0, CSR_CGB_MODE, '0, rd);
      if (rd != {31'b0, cgb_on})
         flag_mismatch("cgb_mode readback", cgb_on, rd);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (fetch_results_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // tile indexes that map entries may hold
   function automatic logic [7:0] tile_pick(input int p);
      case (p)
         0: return 8'h01;
         1: return 8'h7F;
         2: return 8'h80;
         default: return 8'hFF;
      endcase
   endfunction

   function automatic logic [7:0] vram_byte(input int addr);
      if (addr >= MAP_LO && addr < BANK_BYTES)
         return tile_pick($urandom_range(0, TILE_PICKS - 1));
      return 8'($urandom);
   endfunction

   // map rows reachable by the stimulus, and the tiles those maps can name, in both banks
   function automatic void build_load_list();
      int idx;
      for (int bank = 0; bank < 2; bank++) begin
         for (int m = 0; m < 2; m++)
            for (int a = 0; a < MAP_ROWS * 32; a++)
               load_addrs.push_back(bank * BANK_BYTES + MAP_LO + m * (MAP_HI - MAP_LO) + a);
         for (int p = 0; p < TILE_PICKS; p++) begin
            idx = int'(tile_pick(p));
            for (int b = 0; b < 16; b++) begin
               load_addrs.push_back(bank * BANK_BYTES + idx * 16 + b);
               if (idx < 128)
                  load_addrs.push_back(bank * BANK_BYTES + SIGNED_BASE + idx * 16 + b);
            end
         end
      end
   endfunction

   // keeps map rows and write addresses inside the loaded area
   function automatic req_type fit_fetch(input req_type r);
      logic [7:0] ysum;
      int a;
      ysum = 8'($urandom_range(0, MAP_ROWS * 8 - 1));
      r.scroll_y = ysum - r.line;
      r.window_line = 8'($urandom_range(0, MAP_ROWS * 8 - 1));
      a = load_addrs[$urandom_range(0, load_addrs.size() - 1)];
      r.vram_addr = 14'(a);
      r.vram_data = vram_byte(a);
      return r;
   endfunction

   function automatic void start_scanline();
      logic [95:0] bits;
      bits = {$urandom, $urandom, $urandom};
      scan_ctx = bits[$bits(req_type)-1:0];
      scan_ctx.line = 8'($urandom_range(0, 153));
      scan_ctx = fit_fetch(scan_ctx);
      scan_ctx.screen_x = '0;
      scan_ctx.window_x = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 60));
      scan_ctx.window_y = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                      : 8'($urandom_range(0, scan_ctx.line));
      if ($urandom_range(0, 9) < 6)
         scan_ctx.lcd_control[LCDC_WIN_EN] = 1'b1;
   endfunction

   function automatic void add_row(req_type item, bit typed, rsp_type want);
      dir_row_type row;
      row.item = item;
      row.typed = typed;
      row.want = want;
      stim_table.push_back(row);
   endfunction

   // Mostly ticks along a scan line, with writes, line restarts and noise mixed in.
   task automatic run_random(input int count, input int hold_at);
      req_type r;
      logic [95:0] bits;
      int n, pick;
      n = 0;
      start_scanline();
      while (n < count) begin
         pick = $urandom_range(0, 99);
         bits = {$urandom, $urandom, $urandom};
         r = bits[$bits(req_type)-1:0];
         r.line = 8'($urandom_range(0, 153));
         r = fit_fetch(r);
         if (pick < 80) begin
            r = scan_ctx;
            r.operation = OP_TICK;
            r.fifo_ready = ($urandom_range(0, 99) < 85);
            scan_ctx.screen_x++;
         end else if (pick < 90) begin
            r.operation = OP_WRITE;
         end else if (pick < 92) begin
            r.operation = OP_LINE;
            start_scanline();
         end else if (pick < 95) begin
            r.operation = OP_UNKNOWN;
         end else begin
            r.operation = 2'($urandom_range(0, 3));
         end
         if (r.operation != OP_UNKNOWN)
            n++;
         if (n == hold_at) begin
            hold_left = HOLD_CYCLES;
            hold_at = -1;
         end
         send_item(r, 1'b0, '0);
      end
   endtask

   initial begin
      req_type it;
      rsp_type w;
      logic [95:0] bits;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cgb_on = 1'b0;
      fetch_ph = PH_MAP;
      div_count = '0;
      tile_col = '0;
      win_on = 1'b0;
      tile_idx = '0;
      tile_attr_q = '0;
      plane_lo = '0;
      plane_hi = '0;
      foreach (vram_img[i])
         vram_img[i] = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      set_cgb_mode(1'b1);

      // preload every byte a fetch can reach so no fetch reads an unwritten byte
      build_load_list();
      foreach (load_addrs[i]) begin
         bits = {$urandom, $urandom, $urandom};
         it = bits[$bits(req_type)-1:0];
         it.operation = OP_WRITE;
         it.vram_addr = 14'(load_addrs[i]);
         it.vram_data = vram_byte(load_addrs[i]);
         send_item(it, 1'b0, '0);
      end

      it = '0; it.operation = OP_TICK;                       add_row(it, 1'b1, '0);
      it = '1; it.operation = OP_WRITE; it.line = 8'd153;   add_row(it, 1'b1, '0);
      it = '0; it.operation = OP_WRITE;                      add_row(it, 1'b1, '0);
      it = '1; it.operation = OP_UNKNOWN; it.line = 8'd153; add_row(it, 1'b1, '0);
      it = '1; it.operation = OP_LINE; it.line = 8'd153;    add_row(it, 1'b1, '0);
      // window at x=0 only starts if the edge compare is signed
      it = '1;
      it.operation = OP_TICK;
      it.line = 8'd153;
      it.window_y = '0;
      it.window_x = '0;
      it.screen_x = '0;
      it.window_line = 8'h0F;
      for (int k = 1; k <= 10; k++) begin
         w = '0;
         w.flush_fifos = 1'b1;
         add_row(it, k == 2, w);
      end
      it.operation = OP_LINE;                              add_row(it, 1'b1, '0);
      // background, signed tile data, scroll sums wrapping, last push refused
      it = '0;
      it.operation = OP_TICK;
      it.line = 8'd153;
      it.scroll_y = 8'd110;
      it.scroll_x = 8'hFF;
      it.fifo_ready = 1'b1;
      for (int k = 1; k <= 10; k++) begin
         it.fifo_ready = (k != 10);
         add_row(it, 1'b0, '0);
      end

      send_idle_pct = 16;
      recv_idle_pct = 67;
      foreach (stim_table[i])
         send_item(stim_table[i].item, stim_table[i].typed, stim_table[i].want);
      run_random(150, -1);
      wait_idle();

      set_cgb_mode(1'b0);
      send_idle_pct = 67;
      recv_idle_pct = 16;
      run_random(150, -1);
      wait_idle();

      set_cgb_mode(1'b1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(150, 75);
      wait_idle();

      if (mismatches == 0)
         $display("** tile_map_pixel_fetcher_top: PASSED **");
      else
         $display("** tile_map_pixel_fetcher_top: FAILED **");
      $finish;
   end

endmodule
